// ===== design/u16u8_pkg.sv =====
// Shared types, widths and the UTF-8 byte encoder for the UTF-16 to UTF-8 transcoder.
// No dependencies; every other design file imports this package.
package u16u8_pkg;

   localparam int CODE_UNIT_W = 16;
   localparam int BYTE_W      = 8;
   localparam int CP_W        = 21;
   localparam int MAX_BYTES   = 4;
   localparam int IDX_W       = $clog2(MAX_BYTES);
   localparam int SURR_BITS_W = 10;

   localparam logic [5:0]      SURR_HIGH_TAG = 6'b110110;
   localparam logic [5:0]      SURR_LOW_TAG  = 6'b110111;
   localparam logic [CP_W-1:0] SUPP_BASE     = 21'h10000;

   // A code point on its way from the surrogate stage to the serializer.
   typedef struct packed {
      logic            valid;
      logic [CP_W-1:0] cp;
   } cp_type;

   // The encoded bytes of one code point and the index of its final byte.
   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [IDX_W-1:0]                 last_idx;
   } enc_type;

   function automatic enc_type utf8_encode(input logic [CP_W-1:0] cp);
      enc_type e;
      e.bytes = '0;
      if (cp < 21'h80) begin
         e.bytes[0] = cp[7:0];
         e.last_idx = IDX_W'(0);
      end else if (cp < 21'h800) begin
         e.bytes[0] = {3'b110, cp[10:6]};
         e.bytes[1] = {2'b10, cp[5:0]};
         e.last_idx = IDX_W'(1);
      end else if (cp < 21'h10000) begin
         e.bytes[0] = {4'b1110, cp[15:12]};
         e.bytes[1] = {2'b10, cp[11:6]};
         e.bytes[2] = {2'b10, cp[5:0]};
         e.last_idx = IDX_W'(2);
      end else begin
         e.bytes[0] = {5'b11110, cp[20:18]};
         e.bytes[1] = {2'b10, cp[17:12]};
         e.bytes[2] = {2'b10, cp[11:6]};
         e.bytes[3] = {2'b10, cp[5:0]};
         e.last_idx = IDX_W'(3);
      end
      return e;
   endfunction

endpackage

// ===== design/u16u8_ifs.sv =====
// Valid/ready channel interfaces for code units in and UTF-8 bytes out.
// Depends on u16u8_pkg for the payload widths.
interface u16u8_req_if import u16u8_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CODE_UNIT_W-1:0] code_unit;
   logic                   end_of_text;

   modport source (output valid, output code_unit, output end_of_text, input ready);
   modport sink (input valid, input code_unit, input end_of_text, output ready);
endinterface

interface u16u8_rsp_if import u16u8_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] utf8_byte;
   logic              last_of_run;

   modport source (output valid, output utf8_byte, output last_of_run, input ready);
   modport sink (input valid, input utf8_byte, input last_of_run, output ready);
endinterface

// ===== design/u16u8_pair.sv =====
// Input stage: surrogate pairing and the registered code point.
// Depends on u16u8_pkg and u16u8_req_if.
module u16u8_pair import u16u8_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   u16u8_req_if.sink    req_chan,
   output cp_type       cp_out,
   input  logic         cp_ready
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [CP_W-1:0]        cp_ff, cp_in;
   logic                   pending_ff, pending_in;
   logic [SURR_BITS_W-1:0] held_ff, held_in;
   logic                   accept, is_high, is_low, emits;

   assign req_chan.ready = !s1_valid_ff || cp_ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_high = req_chan.code_unit[15:10] == SURR_HIGH_TAG;
   assign is_low  = req_chan.code_unit[15:10] == SURR_LOW_TAG;
   assign emits   = !is_high && (!is_low || pending_ff);

   always_comb begin
      if (is_low) begin
         cp_in = {1'b0, held_ff, req_chan.code_unit[9:0]} + SUPP_BASE;
      end else begin
         cp_in = CP_W'(req_chan.code_unit);
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff && !cp_ready;
      pending_in  = pending_ff;
      held_in     = held_ff;
      if (accept) begin
         s1_valid_in = emits;
         pending_in  = is_high && !req_chan.end_of_text;
         held_in     = req_chan.code_unit[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pending_ff  <= 1'b0;
         held_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pending_ff  <= pending_in;
         held_ff     <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cp_ff <= cp_in;
      end
   end

   assign cp_out.valid = s1_valid_ff;
   assign cp_out.cp    = cp_ff;

endmodule

// ===== design/u16u8_ser.sv =====
// Output stage: encodes a code point into UTF-8 and sends its bytes one per transfer.
// Depends on u16u8_pkg and u16u8_rsp_if.
module u16u8_ser import u16u8_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cp_type       cp_in,
   output logic         cp_ready,
   u16u8_rsp_if.source  rsp_chan
);

   logic                             valid_ff, valid_in;
   logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes_ff;
   logic [IDX_W-1:0]                 last_ff;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic                             xfer, final_xfer, load;
   enc_type                          enc;

   assign enc        = utf8_encode(cp_in.cp);
   assign xfer       = rsp_chan.valid && rsp_chan.ready;
   assign final_xfer = xfer && (idx_ff == last_ff);
   assign cp_ready   = !valid_ff || final_xfer;
   assign load       = cp_ready && cp_in.valid;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (cp_ready) begin
         valid_in = cp_in.valid;
         idx_in   = '0;
      end else if (xfer) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= enc.bytes;
         last_ff  <= enc.last_idx;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.utf8_byte   = bytes_ff[idx_ff];
   assign rsp_chan.last_of_run = idx_ff == last_ff;

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff <= last_ff)
      else $error("Byte index ran past the final byte.");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      xfer && !final_xfer |=> valid_ff && idx_ff == $past(idx_ff) + IDX_W'(1))
      else $error("Serializer did not advance to the next byte.");

   a_lead_byte: assert property (@(posedge clock) disable iff (reset)
      valid_ff && idx_ff == '0 |-> rsp_chan.utf8_byte[7:6] != 2'b10)
      else $error("First byte of a sequence is a continuation byte.");

   a_cont_byte: assert property (@(posedge clock) disable iff (reset)
      valid_ff && idx_ff != '0 |-> rsp_chan.utf8_byte[7:6] == 2'b10)
      else $error("Later byte of a sequence is not a continuation byte.");
`endif

endmodule

// ===== design/utf16_to_utf8_transcoder.sv =====
// UTF-16 to UTF-8 transcoder: pairing stage feeding a byte serializer.
// A code point is registered in the pairing stage and then in the serializer's byte register.
// One byte per cycle while output is ready; 1 to 3 bytes per unit, 4 per surrogate pair.
// Units that yield no bytes never block the output.
// Reset is synchronous and clears the pending surrogate and both stages.
module utf16_to_utf8_transcoder import u16u8_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   u16u8_req_if.sink    req_chan,
   u16u8_rsp_if.source  rsp_chan
);

   cp_type cp_link;
   logic   cp_ready;

   u16u8_pair u_pair (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cp_out   (cp_link),
      .cp_ready (cp_ready)
   );

   u16u8_ser u_ser (
      .clock    (clock),
      .reset    (reset),
      .cp_in    (cp_link),
      .cp_ready (cp_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== tb/utf16_to_utf8_transcoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for utf16_to_utf8_transcoder: feeds UTF-16 code units and
// checks every UTF-8 byte against a cycle-free predictor with its own surrogate state.
// Depends on u16u8_pkg, the channel interfaces in u16u8_ifs.sv and the transcoder RTL.
module utf16_to_utf8_transcoder_tb;
   import u16u8_pkg::*;

   localparam int NUM_UNITS   = 460;
   localparam int IDLE_LIMIT  = 2000;
   localparam int LONG_STALL  = 300;
   localparam int STALL_AFTER = 200;

   typedef struct {
      logic [CODE_UNIT_W-1:0] cu;
      logic                   eot;
      logic                   drain_first;
   } unit_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              last;
   } utf8_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   u16u8_req_if req_chan ();
   u16u8_rsp_if rsp_chan ();

   utf16_to_utf8_transcoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   unit_item_type          pending_units[$];
   utf8_out_type           expected_bytes[$];
   logic                   high_waiting;
   logic [SURR_BITS_W-1:0] high_bits_held;
   bit                     drain_next;
   int                     units_accepted;
   int                     bytes_checked;
   int                     pairs_joined;
   int                     mismatches;
   int                     idle_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one accepted code unit to the surrogate state and queues the bytes it yields.
   function automatic void transcode_unit(input logic [CODE_UNIT_W-1:0] cu, input logic eot);
      logic                   was_waiting;
      logic [SURR_BITS_W-1:0] held;
      logic [CP_W-1:0]        cp;
      logic [BYTE_W-1:0]      enc[MAX_BYTES];
      logic [BYTE_W-1:0]      lead;
      int                     count;
      utf8_out_type           out;
      was_waiting    = high_waiting;
      held           = high_bits_held;
      high_waiting   = 1'b0;
      high_bits_held = '0;
      if (cu[15:10] == SURR_HIGH_TAG) begin
         if (!eot) begin
            high_waiting   = 1'b1;
            high_bits_held = cu[SURR_BITS_W-1:0];
         end
         return;
      end
      if (cu[15:10] == SURR_LOW_TAG) begin
         if (!was_waiting) return;
         cp = SUPP_BASE + {held, cu[SURR_BITS_W-1:0]};
         pairs_joined++;
      end else begin
         cp = CP_W'(cu);
      end
      if (cp < 21'h80) begin
         count = 1;
         lead  = 8'h00;
      end else if (cp < 21'h800) begin
         count = 2;
         lead  = 8'hC0;
      end else if (cp < 21'h10000) begin
         count = 3;
         lead  = 8'hE0;
      end else begin
         count = 4;
         lead  = 8'hF0;
      end
      for (int k = count - 1; k > 0; k--) begin
         enc[k] = 8'h80 | BYTE_W'(cp & 21'h3F);
         cp     = cp >> 6;
      end
      enc[0] = lead | BYTE_W'(cp);
      for (int k = 0; k < count; k++) begin
         out.value = enc[k];
         out.last  = (k == count - 1);
         expected_bytes.push_back(out);
      end
   endfunction

   task automatic add_unit(input logic [CODE_UNIT_W-1:0] cu, input logic eot);
      unit_item_type item;
      item.cu          = cu;
      item.eot         = eot;
      item.drain_first = drain_next;
      drain_next       = 1'b0;
      pending_units.push_back(item);
   endtask

   function automatic logic [CODE_UNIT_W-1:0] rand_unit(input int lo, input int hi);
      return CODE_UNIT_W'($urandom_range(lo, hi));
   endfunction

   task automatic add_random_piece();
      logic eot;
      eot = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 15))
         0, 1, 2: add_unit(rand_unit(16'h0000, 16'h007F), eot);
         3, 4:    add_unit(rand_unit(16'h0080, 16'h07FF), eot);
         5, 6: begin
            if ($urandom_range(0, 1) == 0) add_unit(rand_unit(16'h0800, 16'hD7FF), eot);
            else add_unit(rand_unit(16'hE000, 16'hFFFF), eot);
         end
         7, 8, 9, 10: begin
            add_unit(rand_unit(16'hD800, 16'hDBFF), 1'b0);
            add_unit(rand_unit(16'hDC00, 16'hDFFF), eot);
         end
         11: add_unit(rand_unit(16'hDC00, 16'hDFFF), eot);
         12: begin
            add_unit(rand_unit(16'hD800, 16'hDBFF), 1'b0);
            add_unit(rand_unit(16'h0000, 16'hD7FF), eot);
         end
         13: add_unit(rand_unit(16'hD800, 16'hDBFF), 1'b1);
         14: begin
            add_unit(rand_unit(16'hD800, 16'hDBFF), 1'b0);
            add_unit(rand_unit(16'hD800, 16'hDBFF), 1'b0);
            add_unit(rand_unit(16'hDC00, 16'hDFFF), eot);
         end
         default: add_unit(rand_unit(16'h0000, 16'hFFFF), eot);
      endcase
   endtask

   // Sender: bursts of transfers separated by random gaps; an item marked drain_first
   // is held back until every expected byte has been checked.
   always @(posedge clock) begin : drive_units
      int burst_left;
      int gap_left;
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left = $urandom_range(1, 40);
         gap_left   = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            transcode_unit(req_chan.code_unit, req_chan.end_of_text);
            units_accepted++;
            void'(pending_units.pop_front());
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         if (req_chan.valid && !req_chan.ready) begin
            // Hold the offered unit until its transfer completes.
         end else if (gap_left > 0) begin
            req_chan.valid <= 1'b0;
            gap_left--;
         end else if (pending_units.size() != 0 &&
                      !(pending_units[0].drain_first && expected_bytes.size() != 0)) begin
            req_chan.valid       <= 1'b1;
            req_chan.code_unit   <= pending_units[0].cu;
            req_chan.end_of_text <= pending_units[0].eot;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Receiver: cycles through stall patterns, with one long hold-off once enough units are in.
   always @(posedge clock) begin : accept_bytes
      int          stall_left;
      bit          long_stall_done;
      logic [31:0] pattern_cycle;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left      = 0;
         long_stall_done = 1'b0;
         pattern_cycle   = '0;
      end else begin
         if (!long_stall_done && units_accepted >= STALL_AFTER) begin
            stall_left      = LONG_STALL;
            long_stall_done = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            pattern_cycle++;
            case (pattern_cycle[7:6])
               2'd0: rsp_chan.ready <= 1'b1;
               2'd1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               2'd2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= (pattern_cycle[1:0] != 2'd3);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_bytes
      utf8_out_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected byte %h last %b at %0t", rsp_chan.utf8_byte,
                        rsp_chan.last_of_run, $time);
         end else begin
            want = expected_bytes.pop_front();
            if (want.value !== rsp_chan.utf8_byte || want.last !== rsp_chan.last_of_run) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Byte mismatch at %0t: expected %h last %b, got %h last %b", $time,
                           want.value, want.last, rsp_chan.utf8_byte, rsp_chan.last_of_run);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.code_unit   = '0;
      req_chan.end_of_text = 1'b0;
      rsp_chan.ready       = 1'b0;
      high_waiting         = 1'b0;
      high_bits_held       = '0;
      drain_next           = 1'b0;
      units_accepted       = 0;
      bytes_checked        = 0;
      pairs_joined         = 0;
      mismatches           = 0;
      idle_cycles          = 0;

      add_unit(16'h0000, 1'b0);
      add_unit(16'h007F, 1'b0);
      add_unit(16'h0080, 1'b0);
      add_unit(16'h07FF, 1'b0);
      add_unit(16'h0800, 1'b0);
      add_unit(16'hD7FF, 1'b0);
      add_unit(16'hE000, 1'b0);
      add_unit(16'hFFFF, 1'b1);
      add_unit(16'hD800, 1'b0);
      add_unit(16'hDC00, 1'b0);
      add_unit(16'hDBFF, 1'b0);
      add_unit(16'hDFFF, 1'b1);
      add_unit(16'hDC00, 1'b0);
      add_unit(16'hDFFF, 1'b0);
      add_unit(16'hD800, 1'b0);
      add_unit(16'h0041, 1'b0);
      add_unit(16'hD801, 1'b1);
      add_unit(16'hDC00, 1'b0);
      add_unit(16'hD800, 1'b0);
      add_unit(16'hDBFF, 1'b0);
      add_unit(16'hDC01, 1'b0);
      add_unit(16'hD900, 1'b0);
      add_unit(16'h0020, 1'b1);
      add_unit(16'hAAAA, 1'b0);
      add_unit(16'h5555, 1'b0);

      drain_next = 1'b1;
      while (pending_units.size() < NUM_UNITS) begin
         if (pending_units.size() >= 300 && pending_units.size() < 303) drain_next = 1'b1;
         add_random_piece();
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_units.size() != 0) @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d code units (%0d surrogate pairs joined), checked %0d UTF-8 bytes.",
               units_accepted, pairs_joined, bytes_checked);
      $display("Covered broken and lone surrogates, a long output hold-off and full drains.");
      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/u16u8_pkg.sv
design/u16u8_ifs.sv
design/u16u8_pair.sv
design/u16u8_ser.sv
design/utf16_to_utf8_transcoder.sv
tb/utf16_to_utf8_transcoder_tb.sv
